// ===== design/spe_pkg.sv =====
// spe_pkg: shared constants, command and register codes, and payload types
// for the sample playback engine. Depends on nothing; every other file
// refers to it by scoped names.
package spe_pkg;

  // Sizes
  localparam int unsigned SAMPLE_DEPTH = 65536;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned ADDR_W       = $clog2(SAMPLE_DEPTH);
  localparam int unsigned IDX_W        = 17;                 // index, count, window end
  localparam int unsigned POS_W        = FRAC_BITS + IDX_W;  // fixed-point position
  localparam int unsigned RATE_W       = 19;
  localparam int unsigned START_W      = 16;
  localparam int unsigned CMD_W        = 3;
  localparam int unsigned SMP_W        = 16;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 19;

  // Command queue between front and back end
  localparam int unsigned CQ_DEPTH = 4;
  localparam int unsigned CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int unsigned CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  // Result queue
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // Command field codes
  localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REC_START  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REC_SAMPLE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REC_STOP   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TRIGGER    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_STOP       = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PLAY_RATE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE      = 3'd4;

  // Decoded operation held in the command queue
  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_REC_START  = 3'd1,
    OP_REC_SAMPLE = 3'd2,
    OP_REC_STOP   = 3'd3,
    OP_TRIGGER    = 3'd4,
    OP_STOP       = 3'd5
  } op_t;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [SMP_W-1:0] sample_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_out;
    logic                    playing;
  } out_item_t;

  typedef struct packed {
    op_t              op;
    logic [SMP_W-1:0] sample;
  } cmd_entry_t;

  typedef struct packed {
    logic [RATE_W-1:0]  play_rate;
    logic [START_W-1:0] window_start;
    logic [IDX_W-1:0]   window_end;
    logic               loop_enable;
    logic               reverse_enable;
  } cfg_t;

  // Fetched neighbours and flags of one tick, back end to interpolator
  typedef struct packed {
    logic                    zero;
    logic                    playing;
    logic [FRAC_BITS-1:0]    frac;
    logic signed [SMP_W-1:0] s0;
    logic signed [SMP_W-1:0] s1;
  } tick_res_t;

endpackage

// ===== design/spe_front.sv =====
// spe_front: accepts requests, decodes the command field and queues the
// decoded operations for the back end. Depends on spe_pkg.
module spe_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  spe_pkg::in_item_t   in_data,
  input  logic                q_pop,
  output logic                q_valid,
  output spe_pkg::cmd_entry_t q_head
);

  spe_pkg::cmd_entry_t              cq_r [spe_pkg::CQ_DEPTH];
  logic [spe_pkg::CQ_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [spe_pkg::CQ_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [spe_pkg::CQ_CNT_W-1:0]     cnt_r, cnt_nxt;
  spe_pkg::op_t                     dec_op;
  logic                             dec_known;
  logic                             wr_en, rd_en;

  // Command decode; codes six and seven are dropped
  always_comb begin
    dec_op    = spe_pkg::OP_TICK;
    dec_known = 1'b1;
    unique case (in_data.command)
      spe_pkg::CMD_TICK:       dec_op = spe_pkg::OP_TICK;
      spe_pkg::CMD_REC_START:  dec_op = spe_pkg::OP_REC_START;
      spe_pkg::CMD_REC_SAMPLE: dec_op = spe_pkg::OP_REC_SAMPLE;
      spe_pkg::CMD_REC_STOP:   dec_op = spe_pkg::OP_REC_STOP;
      spe_pkg::CMD_TRIGGER:    dec_op = spe_pkg::OP_TRIGGER;
      spe_pkg::CMD_STOP:       dec_op = spe_pkg::OP_STOP;
      default:                 dec_known = 1'b0;
    endcase
  end

  assign in_full = (cnt_r == spe_pkg::CQ_CNT_W'(spe_pkg::CQ_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_head  = cq_r[rd_ptr_r];
  assign wr_en   = in_push && !in_full && dec_known;
  assign rd_en   = q_pop && q_valid;

  // Queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cq_r[wr_ptr_r] <= '{op: dec_op, sample: in_data.sample_in};
    end
  end

  // The back end never takes from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("command queue popped while empty");

  // A dropped command leaves the fill count alone unless the back end pops
  a_drop_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && !dec_known && !q_pop) |=> $stable(cnt_r))
    else $error("unknown command entered the queue");

endmodule

// ===== design/spe_voice.sv =====
// spe_voice: back end of the voice. Holds record and playback state and the
// single-port sample memory, and fetches two neighbours per tick.
// Depends on spe_pkg.
module spe_voice (
  input  logic                clk,
  input  logic                rst_n,
  input  spe_pkg::cfg_t       cfg,
  input  logic                q_valid,
  input  spe_pkg::cmd_entry_t q_head,
  output logic                q_pop,
  input  logic                credit_ok,
  output logic                tick_start,
  output logic                res_vld,
  output spe_pkg::tick_res_t  res
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_READ2 = 2'b10
  } vst_t;

  localparam int unsigned IW = spe_pkg::IDX_W;
  localparam int unsigned FB = spe_pkg::FRAC_BITS;
  localparam int unsigned PW = spe_pkg::POS_W;
  localparam int unsigned AW = spe_pkg::ADDR_W;

  vst_t                       state_r, state_nxt;
  logic [IW-1:0]              rec_idx_r, rec_idx_nxt;
  logic                       recording_r, recording_nxt;
  logic [IW-1:0]              count_r, count_nxt;
  logic                       playing_r, playing_nxt;
  logic [PW-1:0]              pos_r, pos_nxt;
  logic                       advance_r, advance_nxt;
  logic                       res_vld_r, res_vld_nxt;
  logic [FB-1:0]              frac_r, frac_nxt;
  logic                       zero_r, zero_nxt;
  logic                       play_out_r, play_out_nxt;
  logic [AW-1:0]              i1_r, i1_nxt;
  logic [spe_pkg::SMP_W-1:0]  s0_r, s0_nxt;
  logic [spe_pkg::SMP_W-1:0]  rdata_r;
  logic [spe_pkg::SMP_W-1:0]  sample_mem_r [spe_pkg::SAMPLE_DEPTH];

  logic                       mem_we;
  logic [AW-1:0]              mem_addr;

  logic [IW-1:0]              end_w, end_m1, start_w, pos_idx, wrap_idx, i0, i1;
  logic [IW:0]                i0_inc;
  logic                       win_empty, outside, at_edge, tick_live, tick_ends, take;
  logic [PW-1:0]              pos_wrap, rate_ext;

  // Window and position classification for a tick
  always_comb begin
    start_w  = {{(IW - spe_pkg::START_W){1'b0}}, cfg.window_start};
    end_w    = (cfg.window_end == '0 || cfg.window_end > count_r) ? count_r : cfg.window_end;
    end_m1   = end_w - 1'b1;
    win_empty = (start_w >= end_w);
    pos_idx  = pos_r[PW-1:FB];
    if (cfg.reverse_enable) begin
      outside  = pos_r[PW-1] || (pos_idx < start_w) || (pos_idx >= end_w);
      wrap_idx = end_m1;
    end else begin
      outside  = (pos_idx >= end_w);
      wrap_idx = start_w;
    end
    i0       = outside ? wrap_idx : pos_idx;
    i0_inc   = {1'b0, i0} + 1'b1;
    pos_wrap = outside ? {wrap_idx, {FB{1'b0}}} : pos_r;
    // Neighbour: opposite edge with loop, the sample itself without
    if (cfg.reverse_enable) begin
      at_edge = (i0 == start_w);
      i1      = at_edge ? (cfg.loop_enable ? end_m1 : i0) : i0 - 1'b1;
    end else begin
      at_edge = (i0_inc >= {1'b0, end_w});
      i1      = at_edge ? (cfg.loop_enable ? start_w : i0) : i0_inc[IW-1:0];
    end
    tick_ends = playing_r && !win_empty && outside && !cfg.loop_enable;
    tick_live = playing_r && !win_empty && !(outside && !cfg.loop_enable);
    rate_ext  = {{(PW - spe_pkg::RATE_W){1'b0}}, cfg.play_rate};
  end

  assign take       = (state_r == ST_IDLE) && q_valid &&
                      (q_head.op != spe_pkg::OP_TICK || credit_ok);
  assign q_pop      = take;
  assign tick_start = take && (q_head.op == spe_pkg::OP_TICK);

  // Sequencer: each command is handled in the idle state; a tick goes on to ST_READ2 for its second memory read
  always_comb begin
    state_nxt     = state_r;
    rec_idx_nxt   = rec_idx_r;
    recording_nxt = recording_r;
    count_nxt     = count_r;
    playing_nxt   = playing_r;
    pos_nxt       = pos_r;
    advance_nxt   = advance_r;
    res_vld_nxt   = 1'b0;
    frac_nxt      = frac_r;
    zero_nxt      = zero_r;
    play_out_nxt  = play_out_r;
    i1_nxt        = i1_r;
    s0_nxt        = s0_r;
    mem_we        = 1'b0;
    mem_addr      = i0[AW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          unique case (q_head.op)
            spe_pkg::OP_TICK: begin
              state_nxt    = ST_READ2;
              advance_nxt  = tick_live;
              zero_nxt     = !tick_live;
              playing_nxt  = playing_r && !tick_ends;
              play_out_nxt = playing_r && !tick_ends;
              frac_nxt     = pos_wrap[FB-1:0];
              i1_nxt       = i1[AW-1:0];
              if (tick_live) begin
                pos_nxt = pos_wrap;
              end
            end
            spe_pkg::OP_REC_START: begin
              rec_idx_nxt   = '0;
              recording_nxt = 1'b1;
              playing_nxt   = 1'b0;
            end
            spe_pkg::OP_REC_SAMPLE: begin
              mem_addr = rec_idx_r[AW-1:0];
              if (recording_r && rec_idx_r < IW'(spe_pkg::SAMPLE_DEPTH)) begin
                mem_we      = 1'b1;
                rec_idx_nxt = rec_idx_r + 1'b1;
              end
            end
            spe_pkg::OP_REC_STOP: begin
              if (recording_r) begin
                count_nxt = rec_idx_r;
              end
              recording_nxt = 1'b0;
            end
            spe_pkg::OP_TRIGGER: begin
              if (count_r != '0) begin
                pos_nxt     = cfg.reverse_enable ? {end_m1, {FB{1'b0}}}
                                                 : {start_w, {FB{1'b0}}};
                playing_nxt = 1'b1;
              end
            end
            spe_pkg::OP_STOP: begin
              playing_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ2: begin
        state_nxt   = ST_IDLE;
        mem_addr    = i1_r;
        s0_nxt      = rdata_r;
        res_vld_nxt = 1'b1;
        if (advance_r) begin
          pos_nxt = cfg.reverse_enable ? pos_r - rate_ext : pos_r + rate_ext;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rec_idx_r   <= '0;
      recording_r <= 1'b0;
      count_r     <= '0;
      playing_r   <= 1'b0;
      pos_r       <= '0;
      advance_r   <= 1'b0;
      res_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rec_idx_r   <= rec_idx_nxt;
      recording_r <= recording_nxt;
      count_r     <= count_nxt;
      playing_r   <= playing_nxt;
      pos_r       <= pos_nxt;
      advance_r   <= advance_nxt;
      res_vld_r   <= res_vld_nxt;
    end
  end

  // Tick payload
  always_ff @(posedge clk) begin
    frac_r     <= frac_nxt;
    zero_r     <= zero_nxt;
    play_out_r <= play_out_nxt;
    i1_r       <= i1_nxt;
    s0_r       <= s0_nxt;
  end

  // Single-port sample memory, read-first
  always_ff @(posedge clk) begin
    if (mem_we) begin
      sample_mem_r[mem_addr] <= q_head.sample;
    end
    rdata_r <= sample_mem_r[mem_addr];
  end

  assign res_vld = res_vld_r;
  assign res     = '{zero: zero_r, playing: play_out_r, frac: frac_r,
                     s0: s0_r, s1: rdata_r};

  // The second read always returns to the command stage
  a_read2_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ2) |=> (state_r == ST_IDLE))
    else $error("tick sequencer stuck in second read");

  // A fetched pair is handed on only right after the second read
  a_res_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r |-> $past(state_r == ST_READ2))
    else $error("result issued without a completed fetch");

endmodule

// ===== design/spe_interp.sv =====
// spe_interp: linear interpolation pipeline and result queue, with the
// credit count that lets the back end start a tick. Depends on spe_pkg.
module spe_interp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     res_vld,
  input  spe_pkg::tick_res_t       res,
  input  logic                     tick_start,
  output logic                     credit_ok,
  input  logic                     out_pop,
  output logic                     out_empty,
  output spe_pkg::out_item_t       out_data
);

  localparam int unsigned SW     = spe_pkg::SMP_W;
  localparam int unsigned FB     = spe_pkg::FRAC_BITS;
  localparam int unsigned DIFF_W = SW + 1;
  localparam int unsigned PROD_W = DIFF_W + FB + 1;

  // Stage 1: product of difference and fraction
  logic                     v1_r;
  logic                     zero1_r, play1_r;
  logic signed [SW-1:0]     s0_1_r;
  logic signed [PROD_W-1:0] prod1_r, prod1_nxt;
  logic signed [DIFF_W-1:0] diff;
  logic signed [FB:0]       frac_s;

  // Stage 2: product truncated toward zero
  logic                     v2_r;
  logic                     zero2_r, play2_r;
  logic signed [SW-1:0]     s0_2_r;
  logic signed [DIFF_W-1:0] q2_r, q2_nxt;
  logic signed [PROD_W-1:0] biased, shifted;
  logic [PROD_W-1:0]        bias;
  logic signed [DIFF_W:0]   sum;

  // Result queue and credits
  spe_pkg::out_item_t             oq_r [spe_pkg::OQ_DEPTH];
  spe_pkg::out_item_t             wr_item;
  logic [spe_pkg::OQ_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [spe_pkg::OQ_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [spe_pkg::OQ_CNT_W-1:0]   inflight_r, inflight_nxt;
  logic                           wr_en, rd_en;

  assign diff      = $signed({res.s1[SW-1], res.s1}) - $signed({res.s0[SW-1], res.s0});
  assign frac_s    = $signed({1'b0, res.frac});
  assign prod1_nxt = PROD_W'(diff) * PROD_W'(frac_s);

  // Bias a negative product so the arithmetic shift rounds toward zero
  assign bias    = {{(PROD_W - FB){1'b0}}, {FB{prod1_r[PROD_W-1]}}};
  assign biased  = prod1_r + $signed(bias);
  assign shifted = biased >>> FB;
  assign q2_nxt  = shifted[DIFF_W-1:0];

  assign sum     = $signed({s0_2_r[SW-1], s0_2_r[SW-1], s0_2_r}) +
                   $signed({q2_r[DIFF_W-1], q2_r});
  assign wr_item = '{sample_out: zero2_r ? '0 : sum[SW-1:0], playing: play2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= res_vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    zero1_r <= res.zero;
    play1_r <= res.playing;
    s0_1_r  <= res.s0;
    prod1_r <= prod1_nxt;
    zero2_r <= zero1_r;
    play2_r <= play1_r;
    s0_2_r  <= s0_1_r;
    q2_r    <= q2_nxt;
  end

  assign wr_en     = v2_r;
  assign out_empty = (cnt_r == '0);
  assign rd_en     = out_pop && !out_empty;
  assign out_data  = oq_r[rd_ptr_r];
  assign credit_ok = (inflight_r < spe_pkg::OQ_CNT_W'(spe_pkg::OQ_DEPTH));

  // Occupancy of the queue and results owed to it
  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
    inflight_nxt = inflight_r;
    if (tick_start && !rd_en) begin
      inflight_nxt = inflight_r + 1'b1;
    end else if (rd_en && !tick_start) begin
      inflight_nxt = inflight_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      cnt_r      <= '0;
      inflight_r <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r      <= cnt_nxt;
      inflight_r <= inflight_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      oq_r[wr_ptr_r] <= wr_item;
    end
  end

  // Credits keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (cnt_r != spe_pkg::OQ_CNT_W'(spe_pkg::OQ_DEPTH)) || rd_en)
    else $error("result queue overflow");

  // Queued results are always covered by outstanding credits
  a_credit_cover: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= inflight_r)
    else $error("result queue holds more than was started");

endmodule

// ===== design/sample_playback_engine.sv =====
// sample_playback_engine: top level of the sampler voice. Holds the
// configuration registers and joins front end, back end and interpolator.
// Depends on spe_pkg, spe_front, spe_voice and spe_interp.
//
// One sampler voice with record and interpolated playback over a 64 Ki x 16
// single-port sample memory. Requests enter a four-deep command queue;
// the back end completes any command other than a tick in its idle state,
// and a tick goes on to a second memory read, one read per neighbouring
// sample, so no new command is taken during it. A tick's result passes
// from the fetched pair register through the interpolator stages into the
// result queue, and the back end holds further ticks while four results
// are owed to the result side, waiting there or still in the interpolator.
// Codes six and seven are accepted and dropped. The sample memory is not
// cleared: playback reads only entries below the length fixed by the last
// record stop, all of which were written by earlier requests.
// Configuration writes take effect on the next cycle and must be made only
// while the block is idle.
module sample_playback_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  spe_pkg::in_item_t                 in_data,
  input  logic                              out_pop,
  output logic                              out_empty,
  output spe_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [spe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spe_pkg::CFG_DATA_W-1:0]    cfg_data
);

  spe_pkg::cfg_t       cfg_r;
  spe_pkg::cmd_entry_t q_head;
  spe_pkg::tick_res_t  res;
  logic                q_valid, q_pop, credit_ok, tick_start, res_vld;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.play_rate      <= spe_pkg::RATE_W'(1) << spe_pkg::FRAC_BITS;
      cfg_r.window_start   <= '0;
      cfg_r.window_end     <= '0;
      cfg_r.loop_enable    <= 1'b0;
      cfg_r.reverse_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spe_pkg::CFG_PLAY_RATE:    cfg_r.play_rate      <= cfg_data[spe_pkg::RATE_W-1:0];
        spe_pkg::CFG_WINDOW_START: cfg_r.window_start   <= cfg_data[spe_pkg::START_W-1:0];
        spe_pkg::CFG_WINDOW_END:   cfg_r.window_end     <= cfg_data[spe_pkg::IDX_W-1:0];
        spe_pkg::CFG_LOOP_ENABLE:  cfg_r.loop_enable    <= cfg_data[0];
        spe_pkg::CFG_REVERSE:      cfg_r.reverse_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  spe_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_head  (q_head)
  );

  spe_voice u_voice (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .credit_ok  (credit_ok),
    .tick_start (tick_start),
    .res_vld    (res_vld),
    .res        (res)
  );

  spe_interp u_interp (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_vld    (res_vld),
    .res        (res),
    .tick_start (tick_start),
    .credit_ok  (credit_ok),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_data   (out_data)
  );

endmodule

// ===== bench/tb_sample_playback_engine.sv =====
// tb_sample_playback_engine: self-checking bench for the sampler voice, with a
// request driver, a result monitor and a bit-true voice predictor.
// Depends on spe_pkg and sample_playback_engine.
module tb_sample_playback_engine;

  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 16;      // covers the command queue and the tick pipeline, with margin
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASES        = 12;
  localparam int LIMIT_CYCLES  = 600_000;

  // Codes the block must drop or ignore
  localparam logic [spe_pkg::CMD_W-1:0] CMD_SPARE_A = spe_pkg::CMD_STOP + 3'd1;
  localparam logic [spe_pkg::CMD_W-1:0] CMD_SPARE_B = spe_pkg::CMD_STOP + 3'd2;
  localparam int CFG_SPARE_FIRST = int'(spe_pkg::CFG_REVERSE) + 1;
  localparam int CFG_SPARE_LAST  = (1 << spe_pkg::CFG_IDX_W) - 1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                                in_push   = 1'b0;
  logic                                in_full;
  spe_pkg::in_item_t                   in_data   = '0;
  logic                                out_pop   = 1'b0;
  logic                                out_empty;
  spe_pkg::out_item_t                  out_data;
  logic                                cfg_we    = 1'b0;
  logic [spe_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [spe_pkg::CFG_DATA_W-1:0]      cfg_data  = '0;

  // Stimulus and checking state
  spe_pkg::in_item_t  pending_req[$];
  spe_pkg::out_item_t due_out[$];
  int  send_idle_pct = 24;
  int  recv_idle_pct = 76;
  bit  hold_req      = 1'b0;
  int  hold_left     = 0;
  int  sent_count    = 0;
  int  checked_count = 0;
  int  faults        = 0;

  // Predicted voice state
  logic [spe_pkg::SMP_W-1:0] sample_mem [spe_pkg::SAMPLE_DEPTH];
  logic [spe_pkg::IDX_W-1:0] rec_idx  = '0;
  bit                        rec_on   = 1'b0;
  logic [spe_pkg::IDX_W-1:0] take_len = '0;
  bit                        voice_on = 1'b0;
  logic [spe_pkg::POS_W-1:0] play_pos = '0;
  spe_pkg::cfg_t             voice_cfg;

  sample_playback_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned window_limit();
    if (voice_cfg.window_end == 0 || voice_cfg.window_end > take_len) return 32'(take_len);
    return 32'(voice_cfg.window_end);
  endfunction

  function automatic longint stored_sample(int unsigned idx);
    if (idx >= spe_pkg::SAMPLE_DEPTH) return 0;
    return longint'(signed'(sample_mem[idx]));
  endfunction

  // One playback tick: edge handling, neighbour fetch, interpolation, advance
  function automatic logic [15:0] voice_tick();
    int unsigned lim, ws, i0, i1, last;
    longint      s0, s1, prod, step;
    logic [15:0] frac;
    if (!voice_on || take_len == 0) return '0;
    lim = window_limit();
    ws  = 32'(voice_cfg.window_start);
    if (ws >= lim) return '0;
    last = lim - 1;
    i0   = 32'(play_pos[32:16]);
    if (voice_cfg.reverse_enable) begin
      // reversed: the position is two's complement, anything outside wraps or ends
      if (play_pos[32] || i0 < ws || i0 >= lim) begin
        if (!voice_cfg.loop_enable) begin
          voice_on = 1'b0;
          return '0;
        end
        play_pos = {last[16:0], 16'd0};
        i0 = last;
      end
      if (i0 == ws) i1 = voice_cfg.loop_enable ? last : i0;
      else i1 = i0 - 1;
    end else begin
      // forward: only the end edge counts
      if (i0 >= lim) begin
        if (!voice_cfg.loop_enable) begin
          voice_on = 1'b0;
          return '0;
        end
        play_pos = {1'b0, voice_cfg.window_start, 16'd0};
        i0 = ws;
      end
      if (i0 + 1 >= lim) i1 = voice_cfg.loop_enable ? ws : i0;
      else i1 = i0 + 1;
    end
    // fraction after any wrap, truncated toward zero
    frac = play_pos[15:0];
    s0   = stored_sample(i0);
    s1   = stored_sample(i1);
    prod = (s1 - s0) * longint'(frac);
    step = (prod >= 0) ? (prod >>> 16) : -((-prod) >>> 16);
    if (voice_cfg.reverse_enable) play_pos = play_pos - {14'd0, voice_cfg.play_rate};
    else play_pos = play_pos + {14'd0, voice_cfg.play_rate};
    return 16'(s0 + step);
  endfunction

  // Apply one accepted request to the predicted state
  function automatic void voice_apply(spe_pkg::in_item_t req);
    spe_pkg::out_item_t res;
    int unsigned        last;
    case (req.command)
      spe_pkg::CMD_TICK: begin
        res.sample_out = voice_tick();
        res.playing    = voice_on;
        due_out.push_back(res);
      end
      spe_pkg::CMD_REC_START: begin
        rec_idx  = '0;
        rec_on   = 1'b1;
        voice_on = 1'b0;
      end
      spe_pkg::CMD_REC_SAMPLE: begin
        if (rec_on && rec_idx < 17'(spe_pkg::SAMPLE_DEPTH)) begin
          sample_mem[rec_idx[15:0]] = req.sample_in;
          rec_idx = rec_idx + 1'b1;
        end
      end
      spe_pkg::CMD_REC_STOP: begin
        if (rec_on) take_len = rec_idx;
        rec_on = 1'b0;
      end
      spe_pkg::CMD_TRIGGER: begin
        if (take_len != 0) begin
          last = window_limit() - 1;
          if (voice_cfg.reverse_enable) play_pos = {last[16:0], 16'd0};
          else play_pos = {1'b0, voice_cfg.window_start, 16'd0};
          voice_on = 1'b1;
        end
      end
      spe_pkg::CMD_STOP: voice_on = 1'b0;
      default: ;
    endcase
  endfunction

  // ------------------------------------------------------------ request driver

  always @(posedge clk) begin : request_driver
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        voice_apply(in_data);
        void'(pending_req.pop_front());
        sent_count++;
      end
      // a request held off by full stays on offer unchanged
      if (!in_push || !in_full) begin
        if (pending_req.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_push <= 1'b1;
          in_data <= pending_req[0];
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------ result monitor

  always @(posedge clk) begin : result_monitor
    spe_pkg::out_item_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (due_out.size() == 0) begin
          $error("result with nothing expected: sample_out %0d playing %0b",
                 out_data.sample_out, out_data.playing);
          faults++;
        end else begin
          want = due_out.pop_front();
          if (out_data.sample_out !== want.sample_out) begin
            $error("sample_out: expected %0d, actual %0d",
                   want.sample_out, out_data.sample_out);
            faults++;
          end
          if (out_data.playing !== want.playing) begin
            $error("playing: expected %0b, actual %0b", want.playing, out_data.playing);
            faults++;
          end
          checked_count++;
        end
      end
      // long back-pressure stretch on request, otherwise random stalls
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ------------------------------------------------------------ stimulus helpers

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic void queue_req(logic [2:0] cmd, logic [15:0] smp);
    spe_pkg::in_item_t r;
    r.command   = cmd;
    r.sample_in = smp;
    pending_req.push_back(r);
  endfunction

  // A take; now and then left open without its record stop
  function automatic void add_take(int n);
    queue_req(spe_pkg::CMD_REC_START, rand_sample());
    repeat (n) queue_req(spe_pkg::CMD_REC_SAMPLE, rand_sample());
    if ($urandom_range(5) != 0) queue_req(spe_pkg::CMD_REC_STOP, rand_sample());
  endfunction

  // Mostly trigger-and-play runs, then plain ticks, takes, stops and noise
  function automatic void add_run();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      queue_req(spe_pkg::CMD_TRIGGER, rand_sample());
      repeat ($urandom_range(3, 12)) queue_req(spe_pkg::CMD_TICK, rand_sample());
    end else if (pick < 65) begin
      repeat ($urandom_range(2, 8)) queue_req(spe_pkg::CMD_TICK, rand_sample());
    end else if (pick < 75) begin
      add_take($urandom_range(1, 40));
    end else if (pick < 83) begin
      queue_req(spe_pkg::CMD_STOP, rand_sample());
      queue_req(spe_pkg::CMD_TICK, rand_sample());
    end else begin
      repeat ($urandom_range(1, 3)) queue_req(3'($urandom_range(7)), rand_sample());
    end
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [18:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      spe_pkg::CFG_PLAY_RATE:    voice_cfg.play_rate      = val;
      spe_pkg::CFG_WINDOW_START: voice_cfg.window_start   = val[15:0];
      spe_pkg::CFG_WINDOW_END:   voice_cfg.window_end     = val[16:0];
      spe_pkg::CFG_LOOP_ENABLE:  voice_cfg.loop_enable    = val[0];
      spe_pkg::CFG_REVERSE:      voice_cfg.reverse_enable = val[0];
      default: ;
    endcase
  endtask

  task automatic release_cfg();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_voice(input logic [18:0] rate, input logic [15:0] ws,
                               input logic [16:0] we, input bit loop, input bit rev);
    write_reg(spe_pkg::CFG_PLAY_RATE, rate);
    write_reg(spe_pkg::CFG_WINDOW_START, {3'd0, ws});
    write_reg(spe_pkg::CFG_WINDOW_END, {2'd0, we});
    write_reg(spe_pkg::CFG_LOOP_ENABLE, {18'd0, loop});
    write_reg(spe_pkg::CFG_REVERSE, {18'd0, rev});
    release_cfg();
  endtask

  // Settings per phase: extremes on a few, random around the take sizes otherwise
  task automatic setup_phase(input int p);
    logic [18:0] rate;
    int          pick;
    case (p)
      0: program_voice(19'h7FFFF, 16'd0, 17'd0, 1'b1, 1'b0);
      4: program_voice(19'd0, 16'd0, 17'd65536, 1'b0, 1'b1);
      8: program_voice(19'($urandom_range(1, 19'h7FFFF)), 16'hFFFF, 17'd65536, 1'b1,
                       1'($urandom_range(1)));
      default: begin
        pick = $urandom_range(9);
        if (pick == 0) rate = 19'h7FFFF;
        else if (pick == 1) rate = 19'd0;
        else if (pick < 6) rate = 19'($urandom_range(1, 3 << 16));
        else rate = 19'($urandom_range(1 << 14, 1 << 17));
        program_voice(rate,
                      ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(40)),
                      ($urandom_range(3) == 0) ? 17'd0 : 17'($urandom_range(48)),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    endcase
  endtask

  // Wait for every request and result, then for anything still in the pipe
  task automatic settle();
    while (pending_req.size() != 0 || in_push || due_out.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ------------------------------------------------------------ sequence

  initial begin : run_sequence
    voice_cfg.play_rate      = 19'(1 << spe_pkg::FRAC_BITS);
    voice_cfg.window_start   = '0;
    voice_cfg.window_end     = '0;
    voice_cfg.loop_enable    = 1'b0;
    voice_cfg.reverse_enable = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // unused register indexes must be ignored
    for (int i = CFG_SPARE_FIRST; i <= CFG_SPARE_LAST; i++) write_reg(3'(i), 19'h7FFFF);
    release_cfg();
    @(negedge clk);

    // directed requests at reset settings
    queue_req(spe_pkg::CMD_TICK, 16'h0000);          // idle voice, no take yet
    queue_req(spe_pkg::CMD_TRIGGER, 16'hFFFF);       // empty take: ignored
    queue_req(spe_pkg::CMD_TICK, 16'h0000);
    queue_req(spe_pkg::CMD_REC_SAMPLE, 16'h1234);    // not recording: ignored
    queue_req(spe_pkg::CMD_REC_STOP, 16'h0000);
    queue_req(CMD_SPARE_A, 16'hFFFF);
    queue_req(CMD_SPARE_B, 16'h0000);
    queue_req(spe_pkg::CMD_REC_START, 16'h0000);
    queue_req(spe_pkg::CMD_REC_SAMPLE, 16'h7FFF);
    queue_req(spe_pkg::CMD_REC_SAMPLE, 16'h8000);
    queue_req(spe_pkg::CMD_REC_SAMPLE, 16'h0000);
    queue_req(spe_pkg::CMD_REC_SAMPLE, 16'hFFFF);
    queue_req(spe_pkg::CMD_TRIGGER, 16'h0000);       // take not closed yet: ignored
    queue_req(spe_pkg::CMD_REC_SAMPLE, 16'h0001);
    queue_req(spe_pkg::CMD_REC_SAMPLE, 16'h5A5A);
    queue_req(spe_pkg::CMD_REC_STOP, 16'h0000);
    queue_req(spe_pkg::CMD_TRIGGER, 16'h0000);
    repeat (7) queue_req(spe_pkg::CMD_TICK, 16'h0000);  // last tick runs off the end
    queue_req(spe_pkg::CMD_TRIGGER, 16'h0000);
    queue_req(spe_pkg::CMD_TICK, 16'h0000);
    queue_req(spe_pkg::CMD_STOP, 16'h0000);
    queue_req(spe_pkg::CMD_TICK, 16'h0000);
    queue_req(spe_pkg::CMD_TRIGGER, 16'h0000);
    queue_req(spe_pkg::CMD_TICK, 16'h0000);
    queue_req(spe_pkg::CMD_REC_START, 16'h0000);     // halts playback
    queue_req(spe_pkg::CMD_TICK, 16'h0000);

    // random phases under three idling profiles
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p / 4)
        0: begin send_idle_pct = 24; recv_idle_pct = 76; end
        1: begin send_idle_pct = 76; recv_idle_pct = 24; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      setup_phase(p);
      @(negedge clk);
      while (pending_req.size() < ((p == 2) ? 56 : 36)) add_run();
      if (p == 2) hold_req = 1'b1;
    end

    settle();
    $display("Covered %0d requests and %0d checked ticks over %0d register settings,",
             sent_count, checked_count, PHASES + 1);
    $display("with an empty-window phase and a %0d-cycle stall of the result side.",
             HOLD_CYCLES);
    if (faults == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("timeout: run did not complete");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sample_playback_engine.f =====
design/spe_pkg.sv
design/spe_front.sv
design/spe_voice.sv
design/spe_interp.sv
design/sample_playback_engine.sv
bench/tb_sample_playback_engine.sv
